[hw/rtl/windowed_median_pixel_filter_unit_macros.svh]
// Assertion macros used by the median filter RTL.
`ifndef WINDOWED_MEDIAN_PIXEL_FILTER_UNIT_MACROS_SVH
`define WINDOWED_MEDIAN_PIXEL_FILTER_UNIT_MACROS_SVH
`ifndef SYNTH
`define MFU_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define MFU_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);
`else
`define MFU_ASSERT_IMP(lbl, ante, cons, msg)
`define MFU_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

[hw/rtl/mfu_pkg.sv]
package mfu_pkg;
  localparam int MAX_KERNEL = 7;
  localparam int MAX_WIDTH  = 2048;
  localparam int MAX_HEIGHT = 4096;
  localparam int NCELL      = MAX_KERNEL * MAX_KERNEL;
  localparam int COLW       = $clog2(MAX_WIDTH);
  localparam int ROWW       = $clog2(MAX_HEIGHT);
  localparam int KW         = 3;
  localparam int SLOTW      = $clog2(MAX_KERNEL);
  localparam int ADDRW      = SLOTW + COLW;
  localparam int MEM_DEPTH  = MAX_KERNEL * MAX_WIDTH;
  localparam int LANES      = 3;
  localparam int PIXW       = 8 * LANES;
  localparam int KKW        = $clog2(NCELL + 1);
  localparam int SELW       = $clog2(NCELL);
  localparam int CFGIW      = 3;
  localparam int CFGDW      = 13;

  localparam logic [CFGIW-1:0] REG_KERNEL = 3'd0;
  localparam logic [CFGIW-1:0] REG_COLOR  = 3'd1;
  localparam logic [CFGIW-1:0] REG_WIDTH  = 3'd2;
  localparam logic [CFGIW-1:0] REG_HEIGHT = 3'd3;

  // Link between neighboring sorter cells: gt and vld, one bit per channel lane, and val.
  typedef struct packed {
    logic [LANES-1:0] gt;
    logic [LANES-1:0] vld;
    logic [PIXW-1:0]  val;
  } cell_link_t;
endpackage

[hw/rtl/mfu_if.sv]
interface mfu_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] chan0;
  logic [7:0] chan1;
  logic [7:0] chan2;
  modport source (output valid, chan0, chan1, chan2, input ready);
  modport sink (input valid, chan0, chan1, chan2, output ready);
endinterface

interface mfu_res_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_chan0;
  logic [7:0]  out_chan1;
  logic [7:0]  out_chan2;
  logic [11:0] out_row;
  logic [10:0] out_col;
  logic        frame_last;
  modport source (output valid, out_chan0, out_chan1, out_chan2, out_row, out_col,
                  frame_last, input ready);
  modport sink (input valid, out_chan0, out_chan1, out_chan2, out_row, out_col,
                frame_last, output ready);
endinterface

[hw/rtl/mfu_line_store.sv]
module mfu_line_store
  import mfu_pkg::*;
(
  input  logic             clk,
  input  logic             we,
  input  logic [ADDRW-1:0] waddr,
  input  logic [PIXW-1:0]  wdata,
  input  logic [ADDRW-1:0] raddr,
  output logic [PIXW-1:0]  rdata
);
  logic [PIXW-1:0] mem [0:MEM_DEPTH-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

[hw/rtl/mfu_cell.sv]
module mfu_cell
  import mfu_pkg::*;
(
  input  logic            clk,
  input  logic            clr,
  input  logic            ins,
  input  logic [PIXW-1:0] x,
  input  cell_link_t      prev,
  output cell_link_t      self
);
  logic [PIXW-1:0]  val;
  logic [LANES-1:0] vld;
  logic [LANES-1:0] gt;

  // An empty cell counts as larger than any value.
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      gt[l] = !vld[l] || (val[l*8 +: 8] > x[l*8 +: 8]);
    end
  end

  always_ff @(posedge clk) begin
    if (clr) begin
      vld <= '0;
    end else if (ins) begin
      for (int l = 0; l < LANES; l++) begin
        if (gt[l]) begin
          if (prev.gt[l]) begin
            val[l*8 +: 8] <= prev.val[l*8 +: 8];
            vld[l]        <= prev.vld[l];
          end else begin
            val[l*8 +: 8] <= x[l*8 +: 8];
            vld[l]        <= 1'b1;
          end
        end
      end
    end
  end

  assign self.gt  = gt;
  assign self.vld = vld;
  assign self.val = val;
endmodule

[hw/rtl/mfu_sorter.sv]
module mfu_sorter
  import mfu_pkg::*;
(
  input  logic            clk,
  input  logic            clr,
  input  logic            ins,
  input  logic [PIXW-1:0] x,
  input  logic [SELW-1:0] sel,
  output logic [PIXW-1:0] median
);
  cell_link_t link [0:NCELL];

  assign link[0] = '0;

  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    mfu_cell u_cell (
      .clk (clk),
      .clr (clr),
      .ins (ins),
      .x   (x),
      .prev(link[i]),
      .self(link[i+1])
    );
  end

  always_comb begin
    median = '0;
    for (int i = 0; i < NCELL; i++) begin
      if (sel == SELW'(i)) begin
        median = link[i+1].val;
      end
    end
  end
endmodule

[hw/rtl/windowed_median_pixel_filter_unit.sv]
// Windowed median pixel filter.
// Pixels enter on pix_in in raster order, one beat per pixel with the three
// channels side by side. When a pixel completes a kernel_size square window,
// one beat leaves on res_out with the per-channel median, the window's
// top-left row and column, and frame_last on the last window of the frame.
// Gray mode filters channel 0 only and sends zero on the other channels.
// A pixel that completes no window gives no beat. A pixel that completes a
// window is followed by K*K reads of the single read port of the line
// store, fed one a cycle into a chain of insertion cells, then a drain step
// and a step that loads the output. Configuration is written through
// cfg_we, cfg_index and cfg_data while the block is idle, which the user
// must ensure as the block does not check; any write restarts the frame at
// row 0, column 0. Reset returns the registers to K=3, gray, 640 x 480 and
// restarts the frame; the line store needs no clearing since every window
// reads only pixels of the current frame. The output register holds a beat
// until res_out.ready; a new pixel is still taken meanwhile, and only a
// second finished window waits for the register to empty.
module windowed_median_pixel_filter_unit
  import mfu_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  mfu_pix_if.sink          pix_in,
  mfu_res_if.source        res_out,
  input  logic             cfg_we,
  input  logic [CFGIW-1:0] cfg_index,
  input  logic [CFGDW-1:0] cfg_data
);
`include "windowed_median_pixel_filter_unit_macros.svh"

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_LOAD  = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  // Configuration registers.
  logic [KW-1:0]   kernel_size;
  logic            color_mode;
  logic [11:0]     image_width;
  logic [12:0]     image_height;

  // Frame position of the next pixel and its line store slot.
  logic [ROWW-1:0]  row_count;
  logic [COLW-1:0]  col_count;
  logic [SLOTW-1:0] slot;

  logic [1:0]       state;
  logic [KW-1:0]    rd_i;
  logic [KW-1:0]    rd_j;
  logic [SLOTW-1:0] rd_slot;
  logic [COLW-1:0]  rd_col;
  logic             rd_valid;
  logic [KKW-1:0]   ins_cnt;
  logic [ROWW-1:0]  win_top;
  logic [COLW-1:0]  win_left;
  logic             win_last;

  logic            out_valid;
  logic [7:0]      o_chan0;
  logic [7:0]      o_chan1;
  logic [7:0]      o_chan2;
  logic [ROWW-1:0] o_row;
  logic [COLW-1:0] o_col;
  logic            o_last;

  // Effective sizes after clamping the register values.
  logic [KW-1:0]   k_eff;
  logic [KW-1:0]   km1;
  logic [11:0]     w_eff;
  logic [12:0]     h_eff;
  logic [COLW-1:0] wlast;
  logic [ROWW-1:0] hlast;
  logic [KKW-1:0]  kk;

  logic             accept;
  logic             has_win;
  logic [SLOTW:0]   start_sum;
  logic [SLOTW-1:0] start_slot;
  logic [PIXW-1:0]  rdata;
  logic [PIXW-1:0]  median;
  logic             out_free;

  always_comb begin
    k_eff = (kernel_size == '0) ? KW'(1) : kernel_size;
    if (k_eff > KW'(MAX_KERNEL)) begin
      k_eff = KW'(MAX_KERNEL);
    end
    w_eff = (image_width == '0) ? 12'd1 : image_width;
    if (w_eff > 12'(MAX_WIDTH)) begin
      w_eff = 12'(MAX_WIDTH);
    end
    h_eff = (image_height == '0) ? 13'd1 : image_height;
    if (h_eff > 13'(MAX_HEIGHT)) begin
      h_eff = 13'(MAX_HEIGHT);
    end
  end

  assign km1   = k_eff - KW'(1);
  assign wlast = COLW'(w_eff - 12'd1);
  assign hlast = ROWW'(h_eff - 13'd1);
  assign kk    = KKW'(k_eff) * KKW'(k_eff);

  assign pix_in.ready = (state == ST_IDLE);
  assign accept       = pix_in.valid && pix_in.ready;
  assign has_win      = (row_count >= ROWW'(km1)) && (col_count >= COLW'(km1));
  assign out_free     = !out_valid || res_out.ready;

  // The window's top row sits K-1 slots back in the circular line store.
  assign start_sum  = (SLOTW+1)'(slot) + (SLOTW+1)'(MAX_KERNEL) - (SLOTW+1)'(km1);
  assign start_slot = (start_sum >= (SLOTW+1)'(MAX_KERNEL)) ?
                      SLOTW'(start_sum - (SLOTW+1)'(MAX_KERNEL)) : SLOTW'(start_sum);

  always_ff @(posedge clk) begin
    if (rst) begin
      kernel_size  <= KW'(3);
      color_mode   <= 1'b0;
      image_width  <= 12'd640;
      image_height <= 13'd480;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_KERNEL: kernel_size  <= cfg_data[KW-1:0];
        REG_COLOR:  color_mode   <= cfg_data[0];
        REG_WIDTH:  image_width  <= cfg_data[11:0];
        REG_HEIGHT: image_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // Raster position counters.
  always_ff @(posedge clk) begin
    if (rst || cfg_we) begin
      row_count <= '0;
      col_count <= '0;
      slot      <= '0;
    end else if (accept) begin
      if (col_count == wlast) begin
        col_count <= '0;
        if (row_count == hlast) begin
          row_count <= '0;
          slot      <= '0;
        end else begin
          row_count <= row_count + ROWW'(1);
          slot      <= (slot == SLOTW'(MAX_KERNEL - 1)) ? '0 : slot + SLOTW'(1);
        end
      end else begin
        col_count <= col_count + COLW'(1);
      end
    end
  end

  // Sequencer: walks the window row by row through the line store.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= (state == ST_LOAD);
      unique case (state)
        ST_IDLE: begin
          if (accept && has_win) begin
            state    <= ST_LOAD;
            rd_i     <= '0;
            rd_j     <= '0;
            rd_slot  <= start_slot;
            rd_col   <= col_count - COLW'(km1);
            win_top  <= row_count - ROWW'(km1);
            win_left <= col_count - COLW'(km1);
            win_last <= (row_count == hlast) && (col_count == wlast);
          end
        end
        ST_LOAD: begin
          if (rd_j == km1) begin
            rd_j    <= '0;
            rd_col  <= win_left;
            rd_i    <= rd_i + KW'(1);
            rd_slot <= (rd_slot == SLOTW'(MAX_KERNEL - 1)) ? '0 : rd_slot + SLOTW'(1);
            if (rd_i == km1) begin
              state <= ST_DRAIN;
            end
          end else begin
            rd_j   <= rd_j + KW'(1);
            rd_col <= rd_col + COLW'(1);
          end
        end
        ST_DRAIN: state <= ST_DONE;
        ST_DONE: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ins_cnt <= '0;
    end else if (rd_valid) begin
      ins_cnt <= ins_cnt + KKW'(1);
    end
  end

  mfu_line_store u_store (
    .clk  (clk),
    .we   (accept),
    .waddr({slot, col_count}),
    .wdata({pix_in.chan2, pix_in.chan1, pix_in.chan0}),
    .raddr({rd_slot, rd_col}),
    .rdata(rdata)
  );

  mfu_sorter u_sort (
    .clk   (clk),
    .clr   (accept),
    .ins   (rd_valid),
    .x     (rdata),
    .sel   (SELW'(kk >> 1)),
    .median(median)
  );

  // Output register; it frees the sorter as soon as the median is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (res_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && out_free) begin
      o_chan0 <= median[7:0];
      o_chan1 <= color_mode ? median[15:8] : 8'd0;
      o_chan2 <= color_mode ? median[23:16] : 8'd0;
      o_row   <= win_top;
      o_col   <= win_left;
      o_last  <= win_last;
    end
  end

  assign res_out.valid      = out_valid;
  assign res_out.out_chan0  = o_chan0;
  assign res_out.out_chan1  = o_chan1;
  assign res_out.out_chan2  = o_chan2;
  assign res_out.out_row    = o_row;
  assign res_out.out_col    = o_col;
  assign res_out.frame_last = o_last;

  `MFU_ASSERT_IMP(a_all_inserted, state == ST_DONE, ins_cnt == kk, "window not fully sorted")
  `MFU_ASSERT_IMP(a_gray_zero, out_valid && !color_mode, o_chan1 == 8'd0 && o_chan2 == 8'd0, "gray mode lane not zero")
  `MFU_ASSERT_NXT(a_cfg_restart, !rst && cfg_we, row_count == '0 && col_count == '0, "frame not restarted")
endmodule

[verif/windowed_median_pixel_filter_unit_test_if.sv]
`timescale 1ns / 100ps
// The block's own interfaces in hw/rtl/mfu_if.sv are used directly. This file
// holds the record type that the bench keeps in its queue.
package mfu_test_pkg;
  typedef struct packed {
    logic [7:0]  c0;
    logic [7:0]  c1;
    logic [7:0]  c2;
    logic [11:0] row;
    logic [10:0] col;
    logic        last;
  } median_beat_t;
endpackage

[verif/windowed_median_pixel_filter_unit_test.sv]
`timescale 1ns / 100ps
// Bench for the median filter. Pixels are fed in raster order through the
// pixel channel. A behavioral line store and window median predict every
// output beat, and the predicted beats are compared in order with what the
// block sends out.
module windowed_median_pixel_filter_unit_test;
  import mfu_pkg::*;
  import mfu_test_pkg::*;

  // An index that selects no register.
  localparam logic [CFGIW-1:0] REG_UNUSED = 3'd5;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFGIW-1:0] cfg_index = REG_KERNEL;
  logic [CFGDW-1:0] cfg_data = '0;

  mfu_pix_if pix ();
  mfu_res_if res ();

  windowed_median_pixel_filter_unit u_top (
    .clk(clk), .rst(rst), .pix_in(pix), .res_out(res),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Predictor state: the shadow registers and the pixel history of the frame.
  logic [2:0]  kern_reg;
  logic        color_reg;
  logic [11:0] width_reg;
  logic [12:0] height_reg;
  logic [23:0] line_mem [0:MAX_KERNEL*MAX_WIDTH-1];
  int unsigned row_pos, col_pos;

  median_beat_t pending_medians[$];
  int errors = 0;
  int idle_pct = 23;
  int stall_cycles = 0;

  // Effective kernel, width and height after clamping.
  function automatic int unsigned kern_eff();
    return (kern_reg == 0) ? 1 : kern_reg;
  endfunction

  function automatic int unsigned width_eff();
    int unsigned w;
    w = (width_reg == 0) ? 1 : width_reg;
    return (w > MAX_WIDTH) ? MAX_WIDTH : w;
  endfunction

  function automatic int unsigned height_eff();
    int unsigned h;
    h = (height_reg == 0) ? 1 : height_reg;
    return (h > MAX_HEIGHT) ? MAX_HEIGHT : h;
  endfunction

  // Median of one byte lane over the K x K window whose corner is (top, left).
  function automatic logic [7:0] window_median(int unsigned top, int unsigned left,
                                               int unsigned k, int unsigned lane);
    logic [7:0] vals[$];
    logic [23:0] p;
    for (int i = 0; i < k; i++)
      for (int j = 0; j < k; j++) begin
        p = line_mem[((top + i) % MAX_KERNEL) * MAX_WIDTH + left + j];
        vals.push_back(p[lane*8 +: 8]);
      end
    vals.sort();
    return vals[(k * k) / 2];
  endfunction

  // Store one accepted pixel and queue the median beat that it completes.
  task automatic predict_pixel(logic [23:0] px);
    int unsigned k, w, h, r, c;
    median_beat_t b;
    k = kern_eff(); w = width_eff(); h = height_eff();
    r = row_pos; c = col_pos;
    if (c >= w) c = w - 1;
    if (r >= h) r = h - 1;
    line_mem[(r % MAX_KERNEL) * MAX_WIDTH + c] = px;
    if (r + 1 >= k && c + 1 >= k) begin
      b.c0 = window_median(r + 1 - k, c + 1 - k, k, 0);
      b.c1 = color_reg ? window_median(r + 1 - k, c + 1 - k, k, 1) : 8'd0;
      b.c2 = color_reg ? window_median(r + 1 - k, c + 1 - k, k, 2) : 8'd0;
      b.row = 12'(r + 1 - k);
      b.col = 11'(c + 1 - k);
      b.last = (r == h - 1 && c == w - 1);
      pending_medians.push_back(b);
    end
    if (c + 1 >= w) begin
      col_pos = 0;
      row_pos = (r + 1 >= h) ? 0 : r + 1;
    end else begin
      col_pos = c + 1;
      row_pos = r;
    end
  endtask

  // Write one register at an idle moment; every write restarts the frame.
  task automatic write_reg(logic [CFGIW-1:0] idx, logic [CFGDW-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_KERNEL: kern_reg = val[2:0];
      REG_COLOR:  color_reg = val[0];
      REG_WIDTH:  width_reg = val[11:0];
      REG_HEIGHT: height_reg = val[12:0];
      default: ;
    endcase
    row_pos = 0;
    col_pos = 0;
  endtask

  // Wait until every predicted beat has come out, then let the window
  // pipeline run dry before touching the registers.
  task automatic wait_drained();
    while (pending_medians.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic configure(int k, int color, int w, int h);
    wait_drained();
    write_reg(REG_KERNEL, CFGDW'(k));
    write_reg(REG_COLOR, CFGDW'(color));
    write_reg(REG_WIDTH, CFGDW'(w));
    write_reg(REG_HEIGHT, CFGDW'(h));
  endtask

  // Drive one pixel beat and hold it until the block takes it. The beat is
  // predicted at the edge where it is accepted. Valid stays high between
  // back-to-back beats and drops only for an idle gap.
  task automatic send_pixel(logic [23:0] px);
    if (($urandom % 100) < idle_pct) begin
      pix.valid <= 1'b0;
      do @(posedge clk); while (($urandom % 100) < idle_pct);
    end
    pix.valid <= 1'b1;
    pix.chan0 <= px[7:0];
    pix.chan1 <= px[15:8];
    pix.chan2 <= px[23:16];
    do @(posedge clk); while (!pix.ready);
    predict_pixel(px);
  endtask

  task automatic send_frame(int unsigned npix, bit extremes);
    logic [23:0] px;
    for (int i = 0; i < npix; i++) begin
      if (extremes) px = ($urandom % 2) ? 24'hFFFFFF : 24'h000000;
      else if (($urandom % 4) == 0) px = {3{8'($urandom_range(0, 3) * 85)}};
      else px = 24'($urandom);
      send_pixel(px);
    end
    pix.valid <= 1'b0;
  endtask

  // Result side: random back-pressure, in-order field compare.
  always @(posedge clk) begin
    median_beat_t got, want;
    if (rst) begin
      res.ready <= 1'b0;
    end else begin
      if (res.valid && res.ready) begin
        got = {res.out_chan0, res.out_chan1, res.out_chan2, res.out_row,
               res.out_col, res.frame_last};
        if (pending_medians.size() == 0) begin
          $display("%0t: unexpected beat, actual %p", $time, got);
          errors++;
        end else begin
          want = pending_medians.pop_front();
          if (got !== want) begin
            $display("%0t: mismatch, expected %p, actual %p", $time, want, got);
            errors++;
          end
        end
      end
      res.ready <= (($urandom % 100) >= idle_pct);
    end
  end

  // Watchdog on cycles with no accepted beat on either side.
  always @(posedge clk) begin
    if ((pix.valid && pix.ready) || (res.valid && res.ready) || cfg_we || rst)
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles > 20000) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Directed frames: kernel, color, width, height, all-extreme pixels or not.
  typedef struct {
    int k; int color; int w; int h; bit extremes;
  } frame_case_t;

  frame_case_t frame_table[] = '{
    '{3, 0, 5, 4, 1},     // reset-like gray window, black and white pixels
    '{1, 1, 4, 3, 1},     // one-pixel window passes pixels through
    '{7, 1, 8, 8, 0},     // largest kernel
    '{2, 1, 5, 5, 0},     // even kernel takes the upper median
    '{0, 0, 3, 3, 0},     // kernel zero acts as one
    '{7, 0, 5, 9, 0},     // kernel wider than the image: no results at all
    '{3, 1, 1, 1, 0},     // single-pixel frame, nothing fits
    '{1, 0, 1, 6, 0},     // one-column image
    '{1, 1, 2048, 4, 0},  // widest row, first pixels only
    '{1, 0, 0, 0, 0},     // zero sizes act as one
    '{1, 1, 4095, 2, 0},  // width above the maximum saturates, first pixels only
    '{1, 1, 2, 8191, 0}   // height above the maximum, partial frame
  };

  initial begin
    pix.valid = 1'b0;
    pix.chan0 = '0;
    pix.chan1 = '0;
    pix.chan2 = '0;
    kern_reg = 3'd3; color_reg = 1'b0; width_reg = 12'd640; height_reg = 13'd480;
    row_pos = 0; col_pos = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // A few pixels at the reset setting; 640-wide rows give no window yet.
    send_frame(20, 0);

    foreach (frame_table[i]) begin
      configure(frame_table[i].k, frame_table[i].color, frame_table[i].w,
                frame_table[i].h);
      send_frame((frame_table[i].w >= 2048) ? 100 :
                 (frame_table[i].h == 8191) ? 24 :
                 width_eff() * height_eff(), frame_table[i].extremes);
    end

    // Write to an unknown index: only restarts the frame.
    wait_drained();
    write_reg(REG_UNUSED, 13'h1FFF);
    send_frame(width_eff(), 0);

    // Random frames of small sizes; the first phase runs with no idling.
    for (int f = 0; f < 30; f++) begin
      configure($urandom_range(1, 7), $urandom_range(0, 1), $urandom_range(1, 12),
                $urandom_range(1, 8));
      idle_pct = (f < 8) ? 0 : 23;
      if (f == 20) wait_drained();  // hold off the sender until all is out
      send_frame(width_eff() * height_eff() + (($urandom % 5 == 0) ? 3 : 0), 0);
    end

    idle_pct = 23;
    wait_drained();
    repeat (100) @(posedge clk);
    if (errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end
endmodule

[sim.f]
+incdir+hw/rtl
hw/rtl/mfu_pkg.sv
hw/rtl/mfu_if.sv
hw/rtl/mfu_line_store.sv
hw/rtl/mfu_cell.sv
hw/rtl/mfu_sorter.sv
hw/rtl/windowed_median_pixel_filter_unit.sv
verif/windowed_median_pixel_filter_unit_test_if.sv
verif/windowed_median_pixel_filter_unit_test.sv
